// File: src/bpa_pkg.sv
// Package for the page bump allocator: widths, page geometry, command and
// status codes, configuration register indexes and the heap window type.
// No dependencies.
package bpa_pkg;

    // Address space and page geometry
    localparam int ADDR_W       = 32;
    localparam int PAGE_BYTES   = 4096;
    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int PAGE_NUM_W   = ADDR_W - PAGE_SHIFT;
    localparam int PAGES_W      = 21;
    localparam int SIZE_W       = PAGES_W + PAGE_SHIFT;

    // Record stack geometry
    localparam int RECORD_DEPTH = 1024;
    localparam int REC_IDX_W    = $clog2(RECORD_DEPTH);
    localparam int COUNT_W      = $clog2(RECORD_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEAP_START = 2'd0,
        CFG_HEAP_END   = 2'd1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MODE_INIT      = 3'd0,
        MODE_SET_BREAK = 3'd1,
        MODE_BREAK     = 3'd2,
        MODE_ALLOC     = 3'd3,
        MODE_FREE      = 3'd4,
        MODE_QUERY     = 3'd5
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_BEYOND   = 3'd2,
        ST_FULL     = 3'd3,
        ST_IGNORED  = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0] heap_start;
        logic [ADDR_W-1:0] heap_end;
    } t_heap_cfg;

endpackage

// File: src/bpa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module bpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bpa_cfg.sv
// Configuration register file for the heap window (start and end address).
// Depends on bpa_pkg.
module bpa_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]   i_cfg_data,
    output bpa_pkg::t_heap_cfg           o_heap
);
    import bpa_pkg::*;

    t_heap_cfg r_heap;
    logic      cfg_xfer;

    // Writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_xfer    = i_cfg_valid & o_cfg_ready;

    // Decode the index; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap <= '0;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                CFG_HEAP_START: r_heap.heap_start <= i_cfg_data;
                CFG_HEAP_END:   r_heap.heap_end   <= i_cfg_data;
                default:        ;
            endcase
        end
    end

    assign o_heap = r_heap;

endmodule

// File: src/bump_page_allocator_lifo_free.sv
// Top level of the page bump allocator with last-in-first-out free.
// Depends on bpa_pkg, bpa_cfg and bpa_ram.
//
// Use:
//   Commands enter on start/i_mode/i_page_count/i_address and are taken at a
//   rising edge with start high and busy low. Each command gives exactly one
//   result, shown for one cycle with o_done high on o_status, o_block_address
//   and the three byte counts. The receiver cannot stall; a result is gone
//   after its cycle.
//   The heap window is written through the cfg channel (index 0 heap start,
//   index 1 heap end); o_cfg_ready is always high. Write it only while idle.
// Command timing:
//   A command is executed in the cycle after its transfer and its result
//   appears in the cycle after that, with o_done high.
//   busy is high for the execute cycle only; a new command is taken while the
//   result is shown, but not during the execute cycle. The pacing is set by
//   the registered read of the record stack memory, issued at the command
//   transfer and used in the execute cycle.
// Reset:
//   Synchronous, active low. Frontier, frontier start, break, record count and
//   the heap window clear to zero. The record memory needs no clearing pass:
//   only the top entry below the count is ever read, and it is always written
//   first.
module bump_page_allocator_lifo_free (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_mode,
    input  logic [bpa_pkg::PAGES_W-1:0]   i_page_count,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_address,
    // result channel
    output logic                          o_done,
    output logic [2:0]                    o_status,
    output logic [bpa_pkg::ADDR_W-1:0]    o_block_address,
    output logic [bpa_pkg::ADDR_W-1:0]    o_span_bytes,
    output logic [bpa_pkg::ADDR_W-1:0]    o_claimed_bytes,
    output logic [bpa_pkg::ADDR_W-1:0]    o_free_bytes,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpa_pkg::ADDR_W-1:0]    i_cfg_data
);
    import bpa_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    localparam logic [ADDR_W-1:0] PAGE_MASK = ADDR_W'(PAGE_BYTES - 1);

    t_heap_cfg heap;

    t_state              r_state, n_state;
    logic [2:0]          r_mode;
    logic [PAGES_W-1:0]  r_pages;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_frontier, n_frontier;
    logic [ADDR_W-1:0]   r_fstart, n_fstart;
    logic [ADDR_W-1:0]   r_break, n_break;
    logic [COUNT_W-1:0]  r_count, n_count;
    t_status             r_status, n_status;
    logic [ADDR_W-1:0]   r_block, n_block;
    logic                r_done;

    logic                  cmd_xfer;
    logic                  ram_we;
    logic [REC_IDX_W-1:0]  ram_raddr;
    logic [PAGE_NUM_W-1:0] ram_rdata;
    logic [SIZE_W-1:0]     alloc_size;
    logic [ADDR_W+1:0]     alloc_next;
    logic [ADDR_W:0]       round_sum;
    logic [ADDR_W-1:0]     top_base;
    logic [ADDR_W-1:0]     span_bytes;
    logic [ADDR_W-1:0]     claimed_bytes;

    // Heap window registers
    bpa_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_heap      (heap)
    );

    // Record stack of block base pages. The read of the top entry is issued at
    // the command transfer; the previous push was written at an earlier edge,
    // so no forwarding is needed.
    assign cmd_xfer  = start & ~busy;
    assign ram_raddr = REC_IDX_W'(r_count - COUNT_W'(1));

    bpa_ram #(
        .WIDTH (PAGE_NUM_W),
        .DEPTH (RECORD_DEPTH)
    ) u_records (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[REC_IDX_W-1:0]),
        .i_wdata (r_frontier[ADDR_W-1:PAGE_SHIFT]),
        .i_re    (cmd_xfer),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Datapath terms used by the execute cycle
    assign alloc_size = {r_pages, {PAGE_SHIFT{1'b0}}};
    assign alloc_next = {2'b00, r_frontier} + (ADDR_W + 2)'(alloc_size);
    assign round_sum  = {1'b0, heap.heap_start} + {1'b0, PAGE_MASK};
    assign top_base   = {ram_rdata, {PAGE_SHIFT{1'b0}}};

    // Execute the command
    always_comb begin
        n_state    = r_state;
        n_frontier = r_frontier;
        n_fstart   = r_fstart;
        n_break    = r_break;
        n_count    = r_count;
        n_status   = ST_OK;
        n_block    = '0;
        ram_we     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (cmd_xfer) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                case (r_mode)
                    MODE_INIT: begin
                        n_frontier = round_sum[ADDR_W-1:0] & ~PAGE_MASK;
                        n_fstart   = round_sum[ADDR_W-1:0] & ~PAGE_MASK;
                        n_count    = '0;
                    end
                    MODE_SET_BREAK: begin
                        n_break = r_addr;
                    end
                    MODE_BREAK: begin
                        if (r_break == '0) begin
                            n_break = r_addr;
                        end else if (r_addr > r_break && r_addr >= heap.heap_start
                                     && r_addr < r_frontier) begin
                            n_status = ST_REJECTED;
                        end else if (r_addr >= r_break) begin
                            n_break = r_addr;
                        end
                    end
                    MODE_ALLOC: begin
                        if (r_pages == '0) begin
                            n_status = ST_ZERO;
                        end else if (alloc_next > {2'b00, heap.heap_end}) begin
                            n_status = ST_BEYOND;
                        end else if (r_count >= COUNT_W'(RECORD_DEPTH)) begin
                            n_status = ST_FULL;
                        end else begin
                            ram_we     = 1'b1;
                            n_block    = r_frontier;
                            n_frontier = alloc_next[ADDR_W-1:0];
                            n_count    = r_count + COUNT_W'(1);
                        end
                    end
                    MODE_FREE: begin
                        if (r_addr == '0 || r_count == '0 || top_base != r_addr) begin
                            n_status = ST_IGNORED;
                        end else begin
                            n_frontier = top_base;
                            n_count    = r_count - COUNT_W'(1);
                        end
                    end
                    default: ;
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control and allocator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_done     <= 1'b0;
            r_frontier <= '0;
            r_fstart   <= '0;
            r_break    <= '0;
            r_count    <= '0;
        end else begin
            r_state    <= n_state;
            r_done     <= (r_state == S_EXEC);
            r_frontier <= n_frontier;
            r_fstart   <= n_fstart;
            r_break    <= n_break;
            r_count    <= n_count;
        end
    end

    // Hold the command and the result payload
    always_ff @(posedge i_clk) begin
        if (cmd_xfer) begin
            r_mode  <= i_mode;
            r_pages <= i_page_count;
            r_addr  <= i_address;
        end
        if (r_state == S_EXEC) begin
            r_status <= n_status;
            r_block  <= n_block;
        end
    end

    // Byte counts from the updated state
    assign span_bytes    = heap.heap_end - r_fstart;
    assign claimed_bytes = r_frontier - r_fstart;

    assign busy            = (r_state == S_EXEC);
    assign o_done          = r_done;
    assign o_status        = r_status;
    assign o_block_address = r_block;
    assign o_span_bytes    = span_bytes;
    assign o_claimed_bytes = claimed_bytes;
    assign o_free_bytes    = span_bytes - claimed_bytes;

    // A taken command always moves into the execute cycle
    a_xfer_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_xfer |=> (r_state == S_EXEC))
        else $error("command transfer did not start execution");

    // Every result follows exactly one execute cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> o_done)
        else $error("execute cycle produced no result");

    // The record count never exceeds the stack depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= COUNT_W'(RECORD_DEPTH))
        else $error("record count beyond stack depth");

    // A push only happens on a successful allocate and returns the base
    a_push_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |=> (o_done && r_status == ST_OK && r_count == $past(r_count) + COUNT_W'(1)))
        else $error("record push without matching allocate result");

endmodule
